// File: sv/ordered_array_list_assert.svh
// Assertion macros for the ordered array list.
// Each macro carries its own trailing semicolon, so a use stands alone on its line.
`ifndef ORDERED_ARRAY_LIST_ASSERT_SVH
`define ORDERED_ARRAY_LIST_ASSERT_SVH
`ifndef SYNTH
// A property that must hold at every clock edge outside reset.
`define OAL_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("ordered list check failed");
// A consequence that must hold in the same cycle as its trigger.
`define OAL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ordered list check failed");
// A consequence that must hold in the cycle after its trigger.
`define OAL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ordered list check failed");
`else
`define OAL_ASSERT(lbl, clk, rst, prop)
`define OAL_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define OAL_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: sv/oal_pkg.sv
`default_nettype none

package oal_pkg;

   // Default sizes of the list.
   localparam int LIST_DEPTH_DEF = 32;
   localparam int KEY_BITS_DEF   = 64;

   // Fixed widths of the request and response fields.
   localparam int OPCODE_BITS = 3;
   localparam int POS_BITS    = 5;
   localparam int DATA_BITS   = 64;
   localparam int STATUS_BITS = 2;
   localparam int COUNT_BITS  = 6;

   // Operation codes of a request.
   typedef enum logic [OPCODE_BITS-1:0] {
      OP_INSERT = 3'd0,
      OP_APPEND = 3'd1,
      OP_DELETE = 3'd2,
      OP_READ   = 3'd3,
      OP_UPDATE = 3'd4,
      OP_FIND   = 3'd5,
      OP_CLEAR  = 3'd6,
      OP_NOP    = 3'd7
   } op_type;

   // Status codes of a response.
   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2,
      ST_MISS  = 2'd3
   } status_type;

   // Broadcast command to every cell of the chain.
   typedef struct packed {
      logic ins_en;
      logic del_en;
      logic upd_en;
   } cell_ctl_type;

   // Flags that each cell reports back.
   typedef struct packed {
      logic hit;
      logic here;
   } cell_stat_type;

endpackage

`default_nettype wire

// File: sv/oal_cell.sv
`default_nettype none

module oal_cell #(
   parameter int KEY_BITS = oal_pkg::KEY_BITS_DEF,
   parameter int POS_W    = oal_pkg::POS_BITS,
   parameter int INDEX    = 0
) (
   input  logic                          clock,
   input  oal_pkg::cell_ctl_type         ctl,
   input  logic [POS_W-1:0]              pos,
   input  logic [POS_W-1:0]              cnt,
   input  logic [KEY_BITS-1:0]           new_title,
   input  logic [oal_pkg::DATA_BITS-1:0] new_payload,
   input  logic [KEY_BITS-1:0]           key,
   input  logic [KEY_BITS-1:0]           prev_title,
   input  logic [oal_pkg::DATA_BITS-1:0] prev_payload,
   input  logic [KEY_BITS-1:0]           next_title,
   input  logic [oal_pkg::DATA_BITS-1:0] next_payload,
   output logic [KEY_BITS-1:0]           title,
   output logic [oal_pkg::DATA_BITS-1:0] payload,
   output oal_pkg::cell_stat_type        stat
);
   import oal_pkg::*;

   localparam logic [POS_W-1:0] MY_INDEX = POS_W'(INDEX);

   logic [KEY_BITS-1:0]  title_ff;
   logic [KEY_BITS-1:0]  title_in;
   logic [DATA_BITS-1:0] payload_ff;
   logic [DATA_BITS-1:0] payload_in;

   // Choose between holding, taking a neighbour's entry or taking the new entry.
   always_comb begin
      title_in   = title_ff;
      payload_in = payload_ff;
      if (ctl.ins_en) begin
         if (MY_INDEX > pos) begin
            title_in   = prev_title;
            payload_in = prev_payload;
         end else if (MY_INDEX == pos) begin
            title_in   = new_title;
            payload_in = new_payload;
         end
      end else if (ctl.del_en) begin
         if (MY_INDEX >= pos) begin
            title_in   = next_title;
            payload_in = next_payload;
         end
      end else if (ctl.upd_en && (MY_INDEX == pos)) begin
         title_in   = new_title;
         payload_in = new_payload;
      end
   end

   // Entry storage; contents beyond the count are never observed.
   always_ff @(posedge clock) begin
      title_ff   <= title_in;
      payload_ff <= payload_in;
   end

   // Position match and key comparison, valid only below the count.
   assign stat.here = (pos == MY_INDEX);
   assign stat.hit  = (MY_INDEX < cnt) && (title_ff == key);

   assign title   = title_ff;
   assign payload = payload_ff;

endmodule

`default_nettype wire

// File: sv/ordered_array_list.sv
// Channel    Direction  Handshake          Contents
// req_*      in         req_valid/stall    opcode, position, item title and payload
// rsp_*      out        rsp_valid/stall    status, found position, read entry, count
//
// Each request is handled by the whole chain at once: all cells shift, hold or write in
// parallel and compare their titles against the key in the same cycle.
// The response register allows a new request every cycle while rsp_stall is low.
// A request is held off only while a response waits under rsp_stall.
// Synchronous reset empties the list; stored entries need no clearing.
`default_nettype none
`include "ordered_array_list_assert.svh"

module ordered_array_list #(
   parameter int LIST_DEPTH = oal_pkg::LIST_DEPTH_DEF,
   parameter int KEY_BITS   = oal_pkg::KEY_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [oal_pkg::OPCODE_BITS-1:0] req_opcode,
   input  logic [oal_pkg::POS_BITS-1:0]    req_position,
   input  logic [oal_pkg::DATA_BITS-1:0]   req_item_title,
   input  logic [oal_pkg::DATA_BITS-1:0]   req_item_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [oal_pkg::STATUS_BITS-1:0] rsp_status,
   output logic [oal_pkg::POS_BITS-1:0]    rsp_found_position,
   output logic [oal_pkg::DATA_BITS-1:0]   rsp_read_title,
   output logic [oal_pkg::DATA_BITS-1:0]   rsp_read_payload,
   output logic [oal_pkg::COUNT_BITS-1:0]  rsp_entry_count,
   output logic                            rsp_is_empty
);
   import oal_pkg::*;

   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam int CW    = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;

   logic                  req_accept;
   op_type                op;
   logic [CW-1:0]         pos_ext;
   logic [CW-1:0]         cnt_ext;
   logic [CW-1:0]         cell_pos;
   logic [KEY_BITS-1:0]   key;
   logic                  full;
   logic                  pos_in_list;
   logic                  pos_at_most;
   logic [CNT_W-1:0]      cnt_ff;
   logic [CNT_W-1:0]      cnt_in;
   status_type            status_in;
   logic                  ins_req;
   logic                  del_req;
   logic                  upd_req;
   cell_ctl_type          ctl;
   logic [LIST_DEPTH-1:0] hit_vec;
   logic [LIST_DEPTH-1:0] here_vec;
   logic [LIST_DEPTH-1:0] first_hit;
   logic                  any_hit;
   logic [LIST_DEPTH-1:0] rd_sel;
   logic [KEY_BITS-1:0]   rd_title;
   logic [DATA_BITS-1:0]  rd_payload;
   logic [CW-1:0]         fidx;
   logic [CW-1:0]         fpos;
   logic [KEY_BITS-1:0]   title_q   [LIST_DEPTH];
   logic [DATA_BITS-1:0]  payload_q [LIST_DEPTH];
   cell_stat_type         stat_q    [LIST_DEPTH];

   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   logic [POS_BITS-1:0]   rsp_fpos_ff;
   logic [DATA_BITS-1:0]  rsp_title_ff;
   logic [DATA_BITS-1:0]  rsp_payload_ff;
   logic [COUNT_BITS-1:0] rsp_count_ff;
   logic                  rsp_empty_ff;

   // Request handshake: hold off only while a response is stuck.
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // Operand preparation and range checks.
   assign op          = op_type'(req_opcode);
   assign pos_ext     = CW'(req_position);
   assign cnt_ext     = CW'(cnt_ff);
   assign key         = req_item_title[KEY_BITS-1:0];
   assign full        = (cnt_ff == CNT_W'(LIST_DEPTH));
   assign pos_in_list = (pos_ext < cnt_ext);
   assign pos_at_most = (pos_ext <= cnt_ext);
   assign cell_pos    = (op == OP_APPEND) ? cnt_ext : pos_ext;

   // Earliest matching cell, isolated as the lowest set bit.
   assign any_hit   = |hit_vec;
   assign first_hit = hit_vec & (~hit_vec + LIST_DEPTH'(1));

   // Request decode.
   always_comb begin
      status_in = ST_OK;
      cnt_in    = cnt_ff;
      ins_req   = 1'b0;
      del_req   = 1'b0;
      upd_req   = 1'b0;
      rd_sel    = '0;
      case (op)
         OP_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else if (!pos_at_most) begin
               status_in = ST_RANGE;
            end else begin
               ins_req = 1'b1;
               cnt_in  = cnt_ff + CNT_W'(1);
            end
         end
         OP_APPEND: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               ins_req = 1'b1;
               cnt_in  = cnt_ff + CNT_W'(1);
            end
         end
         OP_DELETE: begin
            if (!pos_in_list) begin
               status_in = ST_RANGE;
            end else begin
               del_req = 1'b1;
               cnt_in  = cnt_ff - CNT_W'(1);
            end
         end
         OP_READ: begin
            if (!pos_in_list) begin
               status_in = ST_RANGE;
            end else begin
               rd_sel = here_vec;
            end
         end
         OP_UPDATE: begin
            if (!pos_in_list) begin
               status_in = ST_RANGE;
            end else begin
               upd_req = 1'b1;
            end
         end
         OP_FIND: begin
            if (any_hit) begin
               rd_sel = first_hit;
            end else begin
               status_in = ST_MISS;
            end
         end
         OP_CLEAR: begin
            cnt_in = '0;
         end
         default: begin
         end
      endcase
   end

   // Cell commands only take effect on an accepted request.
   assign ctl.ins_en = req_accept && ins_req;
   assign ctl.del_en = req_accept && del_req;
   assign ctl.upd_en = req_accept && upd_req;

   // Chain of cells, each linked to its lower and upper neighbour.
   for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
      logic [KEY_BITS-1:0]  prev_title;
      logic [DATA_BITS-1:0] prev_payload;
      logic [KEY_BITS-1:0]  next_title;
      logic [DATA_BITS-1:0] next_payload;

      if (g == 0) begin : g_first
         assign prev_title   = key;
         assign prev_payload = req_item_payload;
      end else begin : g_inner_lo
         assign prev_title   = title_q[g-1];
         assign prev_payload = payload_q[g-1];
      end

      if (g == LIST_DEPTH - 1) begin : g_last
         assign next_title   = title_q[g];
         assign next_payload = payload_q[g];
      end else begin : g_inner_hi
         assign next_title   = title_q[g+1];
         assign next_payload = payload_q[g+1];
      end

      oal_cell #(
         .KEY_BITS (KEY_BITS),
         .POS_W    (CW),
         .INDEX    (g)
      ) u_cell (
         .clock        (clock),
         .ctl          (ctl),
         .pos          (cell_pos),
         .cnt          (cnt_ext),
         .new_title    (key),
         .new_payload  (req_item_payload),
         .key          (key),
         .prev_title   (prev_title),
         .prev_payload (prev_payload),
         .next_title   (next_title),
         .next_payload (next_payload),
         .title        (title_q[g]),
         .payload      (payload_q[g]),
         .stat         (stat_q[g])
      );

      assign hit_vec[g]  = stat_q[g].hit;
      assign here_vec[g] = stat_q[g].here;
   end

   // One-hot read selection, merged as an AND-OR tree.
   always_comb begin
      rd_title   = '0;
      rd_payload = '0;
      fidx       = '0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         if (rd_sel[i]) begin
            rd_title   = rd_title | title_q[i];
            rd_payload = rd_payload | payload_q[i];
         end
         if (first_hit[i]) begin
            fidx = fidx | CW'(i);
         end
      end
   end

   assign fpos = ((op == OP_FIND) && any_hit) ? fidx : '0;

   // Entry count.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (req_accept) begin
         cnt_ff <= cnt_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_status_ff  <= status_in;
         rsp_fpos_ff    <= POS_BITS'(fpos);
         rsp_title_ff   <= DATA_BITS'(rd_title);
         rsp_payload_ff <= rd_payload;
         rsp_count_ff   <= COUNT_BITS'(cnt_in);
         rsp_empty_ff   <= (cnt_in == '0);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_position = rsp_fpos_ff;
   assign rsp_read_title     = rsp_title_ff;
   assign rsp_read_payload   = rsp_payload_ff;
   assign rsp_entry_count    = rsp_count_ff;
   assign rsp_is_empty       = rsp_empty_ff;

   // The count never passes the depth of the list.
   `OAL_ASSERT(a_count_bound, clock, reset, cnt_ff <= CNT_W'(LIST_DEPTH))
   // An insert that the cells carry out grows the list by one.
   `OAL_ASSERT_NXT(a_insert_grows, clock, reset, ctl.ins_en, cnt_ff == $past(cnt_ff) + CNT_W'(1))
   // A successful find reads exactly one cell.
   `OAL_ASSERT_IMP(a_find_onehot, clock, reset, req_accept && (op == OP_FIND) && any_hit, $onehot(rd_sel))
   // Every accepted request leaves a response behind.
   `OAL_ASSERT_NXT(a_rsp_follows, clock, reset, req_accept, rsp_valid_ff)

endmodule

`default_nettype wire

// File: tb/oal_tb_pkg.sv
`timescale 1ns / 100ps

package oal_tb_pkg;

   import oal_pkg::*;

   localparam int DEPTH = LIST_DEPTH_DEF;
   localparam logic [DATA_BITS-1:0] KEY_MASK = (KEY_BITS_DEF >= DATA_BITS) ?
      {DATA_BITS{1'b1}} : ((64'd1 << KEY_BITS_DEF) - 64'd1);

   // One response as the list reports it.
   typedef struct packed {
      status_type             status;
      logic [POS_BITS-1:0]    found_position;
      logic [DATA_BITS-1:0]   title;
      logic [DATA_BITS-1:0]   payload;
      logic [COUNT_BITS-1:0]  entry_count;
      logic                   is_empty;
   } list_reply;

   // Shadow copy of the list contents together with the responses still owed.
   class array_list_mirror;
      logic [DATA_BITS-1:0] titles [DEPTH];
      logic [DATA_BITS-1:0] payloads [DEPTH];
      int unsigned          entries;
      int unsigned          peak;
      list_reply            awaited [$];
      int unsigned          mismatches;
      int unsigned          checked;
      int unsigned          by_status [4];

      function new();
         entries    = 0;
         peak       = 0;
         mismatches = 0;
         checked    = 0;
         foreach (by_status[s]) by_status[s] = 0;
         foreach (titles[i]) begin
            titles[i]   = '0;
            payloads[i] = '0;
         end
      endfunction

      // Apply an accepted request to the shadow list and queue its response.
      function void take_request(op_type op, logic [POS_BITS-1:0] pos,
                                 logic [DATA_BITS-1:0] title, logic [DATA_BITS-1:0] payload);
         list_reply            r;
         int unsigned          p;
         int unsigned          i;
         logic [DATA_BITS-1:0] key;
         r.status         = ST_OK;
         r.found_position = '0;
         r.title          = '0;
         r.payload        = '0;
         key              = title & KEY_MASK;
         p                = 32'(pos);
         case (op)
            OP_INSERT, OP_APPEND: begin
               // A full list refuses before the position is looked at.
               if (entries >= DEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  if (op == OP_APPEND) p = entries;
                  if (p > entries) begin
                     r.status = ST_RANGE;
                  end else begin
                     for (i = entries; i > p; i--) begin
                        titles[i]   = titles[i-1];
                        payloads[i] = payloads[i-1];
                     end
                     titles[p]   = key;
                     payloads[p] = payload;
                     entries++;
                  end
               end
            end
            OP_DELETE: begin
               if (p >= entries) begin
                  r.status = ST_RANGE;
               end else begin
                  for (i = p; i + 1 < entries; i++) begin
                     titles[i]   = titles[i+1];
                     payloads[i] = payloads[i+1];
                  end
                  entries--;
               end
            end
            OP_READ: begin
               if (p >= entries) begin
                  r.status = ST_RANGE;
               end else begin
                  r.title   = titles[p];
                  r.payload = payloads[p];
               end
            end
            OP_UPDATE: begin
               if (p >= entries) begin
                  r.status = ST_RANGE;
               end else begin
                  titles[p]   = key;
                  payloads[p] = payload;
               end
            end
            OP_FIND: begin
               // The first match wins; an empty list is a miss.
               r.status = ST_MISS;
               for (i = 0; i < entries; i++) begin
                  if (titles[i] == key) begin
                     r.status         = ST_OK;
                     r.found_position = i[POS_BITS-1:0];
                     r.title          = titles[i];
                     r.payload        = payloads[i];
                     break;
                  end
               end
            end
            OP_CLEAR: begin
               entries = 0;
            end
            default: begin
            end
         endcase
         if (entries > peak) peak = entries;
         r.entry_count = entries[COUNT_BITS-1:0];
         r.is_empty    = (entries == 0);
         awaited.push_back(r);
      endfunction

      function void compare_field(string field, logic [DATA_BITS-1:0] want,
                                  logic [DATA_BITS-1:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
            mismatches++;
         end
      endfunction

      // Compare an accepted response with the oldest outstanding one.
      function void match_response(list_reply got);
         list_reply want;
         if (awaited.size() == 0) begin
            $display("%0t: response with nothing outstanding: expected none, actual status %0d",
                     $time, got.status);
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         checked++;
         by_status[want.status]++;
         compare_field("status", DATA_BITS'(want.status), DATA_BITS'(got.status));
         compare_field("found_position", DATA_BITS'(want.found_position),
                       DATA_BITS'(got.found_position));
         compare_field("read_title", want.title, got.title);
         compare_field("read_payload", want.payload, got.payload);
         compare_field("entry_count", DATA_BITS'(want.entry_count),
                       DATA_BITS'(got.entry_count));
         compare_field("is_empty", DATA_BITS'(want.is_empty), DATA_BITS'(got.is_empty));
      endfunction
   endclass

endpackage

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   import oal_pkg::*;
   import oal_tb_pkg::*;

   localparam int TOTAL_REQUESTS = 1550;
   localparam int QUIET_FROM     = TOTAL_REQUESTS * 85 / 100;
   localparam int WATCHDOG_LIMIT = 500;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [OPCODE_BITS-1:0] req_opcode = '0;
   logic [POS_BITS-1:0]    req_position = '0;
   logic [DATA_BITS-1:0]   req_item_title = '0;
   logic [DATA_BITS-1:0]   req_item_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [STATUS_BITS-1:0] rsp_status;
   logic [POS_BITS-1:0]    rsp_found_position;
   logic [DATA_BITS-1:0]   rsp_read_title;
   logic [DATA_BITS-1:0]   rsp_read_payload;
   logic [COUNT_BITS-1:0]  rsp_entry_count;
   logic                   rsp_is_empty;

   array_list_mirror list_model;
   int unsigned      sent = 0;
   bit               quiet = 1'b0;
   int unsigned      stall_left = 0;
   int unsigned      idle_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ordered_array_list dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_position       (req_position),
      .req_item_title     (req_item_title),
      .req_item_payload   (req_item_payload),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_read_title     (rsp_read_title),
      .rsp_read_payload   (rsp_read_payload),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_is_empty       (rsp_is_empty)
   );

   // Record each accepted request, then check each accepted response.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            list_model.take_request(op_type'(req_opcode), req_position, req_item_title,
                                    req_item_payload);
         if (rsp_valid && !rsp_stall)
            list_model.match_response('{status_type'(rsp_status), rsp_found_position,
                                        rsp_read_title, rsp_read_payload, rsp_entry_count,
                                        rsp_is_empty});
      end
   end

   // Back-pressure on responses in short bursts, with occasional long calm stretches.
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (rsp_stall) begin
         rsp_stall  <= 1'b0;
         stall_left <= ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 5);
      end
   end

   // Give up when neither channel has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: timeout, nothing accepted for %0d cycles", $time, idle_cycles);
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Present one request, hold it until accepted, then maybe leave a gap.
   task automatic issue(input op_type op, input logic [POS_BITS-1:0] pos,
                        input logic [DATA_BITS-1:0] title, input logic [DATA_BITS-1:0] payload);
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_position     <= pos;
      req_item_title   <= title;
      req_item_payload <= payload;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      if (sent >= QUIET_FROM) quiet = 1'b1;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   function automatic logic [DATA_BITS-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // Titles come from a small pool often enough for duplicates and search hits.
   function automatic logic [DATA_BITS-1:0] pick_title();
      case ($urandom_range(0, 3))
         0: return random_word();
         1: return DATA_BITS'($urandom_range(0, 7));
         2: return {1'b1, {(DATA_BITS-4){1'b0}}, 3'($urandom_range(0, 7))};
         default: return $urandom_range(0, 1) ? '1 : '0;
      endcase
   endfunction

   // Mostly a position that the current length allows, sometimes any position.
   function automatic logic [POS_BITS-1:0] pick_pos(bit for_insert);
      int unsigned n;
      n = list_model.entries;
      if ($urandom_range(0, 9) < 8) begin
         if (for_insert)
            return POS_BITS'($urandom_range(0, (n > DEPTH - 1) ? DEPTH - 1 : n));
         if (n > 0) return POS_BITS'($urandom_range(0, n - 1));
      end
      return POS_BITS'($urandom_range(0, DEPTH - 1));
   endfunction

   // Search keys are mostly titles already held in the list.
   function automatic logic [DATA_BITS-1:0] pick_key();
      int unsigned n;
      n = list_model.entries;
      if (n > 0 && $urandom_range(0, 9) < 7) return list_model.titles[$urandom_range(0, n - 1)];
      return pick_title();
   endfunction

   task automatic fill_list();
      while (list_model.entries < DEPTH)
         issue($urandom_range(0, 1) ? OP_APPEND : OP_INSERT, pick_pos(1'b1), pick_title(),
               random_word());
      // Further inserts and appends against the full list.
      repeat ($urandom_range(1, 3))
         issue($urandom_range(0, 1) ? OP_APPEND : OP_INSERT,
               POS_BITS'($urandom_range(0, DEPTH - 1)), pick_title(), random_word());
   endtask

   task automatic drain_list();
      while (list_model.entries > 0) begin
         if ($urandom_range(0, 3) == 0)
            issue($urandom_range(0, 1) ? OP_READ : OP_FIND, pick_pos(1'b0), pick_key(),
                  random_word());
         else
            issue(OP_DELETE, pick_pos(1'b0), random_word(), random_word());
      end
      issue(OP_FIND, POS_BITS'($urandom_range(0, DEPTH - 1)), pick_title(), random_word());
      issue(OP_DELETE, POS_BITS'($urandom_range(0, DEPTH - 1)), random_word(),
            random_word());
   endtask

   task automatic mixed_ops(input int unsigned len);
      int unsigned r;
      repeat (len) begin
         r = $urandom_range(0, 99);
         if (r < 20)      issue(OP_INSERT, pick_pos(1'b1), pick_title(), random_word());
         else if (r < 35) issue(OP_APPEND, POS_BITS'(random_word()), pick_title(),
                                random_word());
         else if (r < 50) issue(OP_DELETE, pick_pos(1'b0), random_word(), random_word());
         else if (r < 65) issue(OP_READ, pick_pos(1'b0), random_word(), random_word());
         else if (r < 75) issue(OP_UPDATE, pick_pos(1'b0), pick_title(), random_word());
         else if (r < 93) issue(OP_FIND, POS_BITS'(random_word()), pick_key(), random_word());
         else if (r < 95) issue(OP_NOP, POS_BITS'(random_word()), random_word(),
                                random_word());
         else if (r < 97) issue(OP_CLEAR, POS_BITS'(random_word()), random_word(),
                                random_word());
         else issue(op_type'($urandom_range(0, 7)), POS_BITS'($urandom_range(0, DEPTH - 1)),
                    random_word(), random_word());
      end
   endtask

   initial begin
      list_model = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed requests: every operation but clear on an empty list, then edge positions and keys.
      issue(OP_NOP, 5'd31, '1, '1);
      issue(OP_READ, 5'd0, '0, '0);
      issue(OP_DELETE, 5'd0, '0, '0);
      issue(OP_UPDATE, 5'd0, '1, '1);
      issue(OP_FIND, 5'd0, '0, '0);
      issue(OP_INSERT, 5'd1, 64'h1, 64'h1);
      issue(OP_INSERT, 5'd0, '1, '1);
      issue(OP_APPEND, 5'd31, '0, '0);
      issue(OP_INSERT, 5'd2, 64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A);
      issue(OP_INSERT, 5'd0, 64'h1, 64'h8000_0000_0000_0001);
      issue(OP_READ, 5'd3, '0, '0);
      issue(OP_READ, 5'd4, '0, '0);
      issue(OP_FIND, 5'd0, '1, '0);
      issue(OP_FIND, 5'd31, '0, '1);
      issue(OP_FIND, 5'd0, 64'h1234, '0);
      issue(OP_UPDATE, 5'd3, '0, 64'hDEAD_BEEF_0000_FFFF);
      issue(OP_FIND, 5'd0, '0, '0);
      issue(OP_DELETE, 5'd0, '0, '0);
      issue(OP_DELETE, 5'd2, '0, '0);
      issue(OP_DELETE, 5'd31, '0, '0);
      issue(OP_CLEAR, 5'd31, '1, '1);
      issue(OP_READ, 5'd0, '0, '0);
      issue(OP_APPEND, 5'd0, 64'h7FFF_FFFF_FFFF_FFFE, '1);
      issue(OP_FIND, 5'd0, 64'h7FFF_FFFF_FFFF_FFFE, '0);

      // Random part: well-formed fills, drains and mixed traffic, with some noise.
      fill_list();
      while (sent < TOTAL_REQUESTS) begin
         case ($urandom_range(0, 9))
            0, 1: fill_list();
            2:    drain_list();
            3:    repeat ($urandom_range(1, 8))
                     issue(op_type'($urandom_range(0, 7)),
                           POS_BITS'($urandom_range(0, DEPTH - 1)),
                           random_word(), random_word());
            default: mixed_ops($urandom_range(5, 40));
         endcase
      end
      req_valid <= 1'b0;

      // Let the outstanding responses arrive, then keep the clock running for strays.
      while (list_model.awaited.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Sent %0d requests and checked %0d responses; the list peaked at %0d entries.",
               sent, list_model.checked, list_model.peak);
      $display("Responses by status: %0d ok, %0d full, %0d out of range, %0d not found.",
               list_model.by_status[ST_OK], list_model.by_status[ST_FULL],
               list_model.by_status[ST_RANGE], list_model.by_status[ST_MISS]);
      if (list_model.mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+sv
sv/oal_pkg.sv
sv/oal_cell.sv
sv/ordered_array_list.sv
tb/oal_tb_pkg.sv
tb/tb_top.sv
